FILE: rtl/dbhb_pkg.sv
// ----------------------------------------------------------------------------
// dbhb_pkg
// Shared types and constants of the deadband and heartbeat storage filter.
// ----------------------------------------------------------------------------
package dbhb_pkg;

    localparam int NUM_TAGS = 256;
    localparam int TAG_W    = 8;
    localparam int VAL_W    = 48;
    localparam int QUAL_W   = 8;
    localparam int TIME_W   = 48;
    localparam int DB_W     = 47;
    localparam int HB_W     = 32;
    localparam int CFG_W    = 47;
    localparam int CFG_IDX_W = 1;
    localparam int DIFF_W   = VAL_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_MIN_DB  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_HB_MS  = 1'd1;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic [QUAL_W-1:0]        quality;
        logic [TIME_W-1:0]        time_ms;
        logic                     time_ok;
    } t_rec;

    typedef struct packed {
        logic                     en;
        logic [TAG_W-1:0]         addr;
        t_rec                     rec;
    } t_rec_wr;

    typedef struct packed {
        logic [TAG_W-1:0]         tag;
        logic                     keep;
        logic signed [VAL_W-1:0]  value;
        logic [QUAL_W-1:0]        quality;
        logic [TIME_W-1:0]        time_ms;
        logic                     time_ok;
        logic [DB_W-1:0]          deadband;
        logic signed [HB_W-1:0]   heartbeat;
    } t_item;

endpackage

FILE: rtl/dbhb_in_if.sv
// ----------------------------------------------------------------------------
// dbhb_in_if
// Sample channel: one tag sample with the tag's settings per beat.
// ----------------------------------------------------------------------------
interface dbhb_in_if;
    import dbhb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TAG_W-1:0]         tag_index;
    logic                     tag_known;
    logic signed [VAL_W-1:0]  sample_value;
    logic [QUAL_W-1:0]        sample_quality;
    logic [TIME_W-1:0]        sample_time_ms;
    logic                     sample_time_valid;
    logic signed [VAL_W-1:0]  tag_storage_deadband;
    logic signed [VAL_W-1:0]  tag_general_deadband;
    logic signed [HB_W-1:0]   tag_heartbeat_ms;

    modport source (
        output valid, tag_index, tag_known, sample_value, sample_quality,
               sample_time_ms, sample_time_valid, tag_storage_deadband,
               tag_general_deadband, tag_heartbeat_ms,
        input  ready
    );

    modport sink (
        input  valid, tag_index, tag_known, sample_value, sample_quality,
               sample_time_ms, sample_time_valid, tag_storage_deadband,
               tag_general_deadband, tag_heartbeat_ms,
        output ready
    );

endinterface

FILE: rtl/dbhb_out_if.sv
// ----------------------------------------------------------------------------
// dbhb_out_if
// Storage channel: one forwarded sample per beat.
// ----------------------------------------------------------------------------
interface dbhb_out_if;
    import dbhb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TAG_W-1:0]         stored_tag;
    logic signed [VAL_W-1:0]  stored_value;
    logic [QUAL_W-1:0]        stored_quality;
    logic [TIME_W-1:0]        stored_time_ms;
    logic                     stored_time_valid;

    modport source (
        output valid, stored_tag, stored_value, stored_quality, stored_time_ms,
               stored_time_valid,
        input  ready
    );

    modport sink (
        input  valid, stored_tag, stored_value, stored_quality, stored_time_ms,
               stored_time_valid,
        output ready
    );

endinterface

FILE: rtl/deadband_heartbeat_store_filter_top.sv
// ----------------------------------------------------------------------------
// deadband_heartbeat_store_filter_top
// Deadband and heartbeat exception filter that keeps one record per tag; it stores
// a tag's first sample, a quality change, enough value change or a due heartbeat.
//
//   Channel   Direction  Handshake              Beat
//   i_in      in         valid/ready            one tag sample with settings
//   o_out     out        valid/ready            one forwarded sample
//   i_cfg_*   in         write enable only      one register write
//
// It accepts one sample per cycle unless the output stalls; a forwarded sample is
// registered with its record read, then registered again at the output.
// Reset clears the presence bit of every tag and both registers.
// A stalled output holds the decision stage, and the input then stops taking beats.
// ----------------------------------------------------------------------------
module deadband_heartbeat_store_filter_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dbhb_in_if.sink                          i_in,
    dbhb_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [dbhb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dbhb_pkg::CFG_W-1:0]       i_cfg_data
);
    import dbhb_pkg::*;

    t_item             item;
    logic              item_valid;
    logic              rd_en;
    logic [TAG_W-1:0]  rd_addr;
    logic              advance;
    t_rec_wr           wr;
    t_rec              rec;
    logic              present;

    dbhb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_advance    (advance),
        .o_item       (item),
        .o_item_valid (item_valid),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr)
    );

    dbhb_records u_records (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .i_wr       (wr),
        .i_look_tag (item.tag),
        .o_rec      (rec),
        .o_present  (present)
    );

    dbhb_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .i_rec        (rec),
        .i_present    (present),
        .o_advance    (advance),
        .o_wr         (wr),
        .o_out        (o_out)
    );

endmodule

FILE: rtl/dbhb_front.sv
// ----------------------------------------------------------------------------
// dbhb_front
// Configuration registers and input register. Resolves the effective deadband
// and heartbeat interval of each sample as it is registered.
// ----------------------------------------------------------------------------
module dbhb_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    dbhb_in_if.sink                          i_in,
    input  logic                             i_cfg_we,
    input  logic [dbhb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dbhb_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_advance,
    output dbhb_pkg::t_item                  o_item,
    output logic                             o_item_valid,
    output logic                             o_rd_en,
    output logic [dbhb_pkg::TAG_W-1:0]       o_rd_addr
);
    import dbhb_pkg::*;

    logic [DB_W-1:0]         r_gmin_db;
    logic signed [HB_W-1:0]  r_def_hb;
    t_item                   r_item;
    t_item                   n_item;
    logic                    r_valid;
    logic                    accept;
    logic [DB_W-1:0]         local_db;

    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        if (!i_in.tag_storage_deadband[VAL_W-1]) begin
            local_db = i_in.tag_storage_deadband[DB_W-1:0];
        end else if (!i_in.tag_general_deadband[VAL_W-1]) begin
            local_db = i_in.tag_general_deadband[DB_W-1:0];
        end else begin
            local_db = '0;
        end

        n_item.tag       = i_in.tag_index;
        n_item.keep      = i_in.tag_known
                           && ({1'b0, i_in.tag_index} < (TAG_W + 1)'(NUM_TAGS));
        n_item.value     = i_in.sample_value;
        n_item.quality   = i_in.sample_quality;
        n_item.time_ms   = i_in.sample_time_ms;
        n_item.time_ok   = i_in.sample_time_valid;
        n_item.deadband  = (r_gmin_db > local_db) ? r_gmin_db : local_db;
        n_item.heartbeat = i_in.tag_heartbeat_ms[HB_W-1] ? r_def_hb
                                                         : i_in.tag_heartbeat_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gmin_db <= '0;
            r_def_hb  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GLOBAL_MIN_DB: r_gmin_db <= i_cfg_data[DB_W-1:0];
                CFG_DEFAULT_HB_MS: r_def_hb  <= i_cfg_data[HB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item       = r_item;
    assign o_item_valid = r_valid;
    assign o_rd_en      = accept;
    assign o_rd_addr    = i_in.tag_index;

endmodule

FILE: rtl/dbhb_records.sv
// ----------------------------------------------------------------------------
// dbhb_records
// Per-tag record memory with registered read, presence bits in flip-flops,
// and a bypass for a record written in the same cycle as it is read.
// ----------------------------------------------------------------------------
module dbhb_records (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [dbhb_pkg::TAG_W-1:0]  i_rd_addr,
    input  dbhb_pkg::t_rec_wr           i_wr,
    input  logic [dbhb_pkg::TAG_W-1:0]  i_look_tag,
    output dbhb_pkg::t_rec              o_rec,
    output logic                        o_present
);
    import dbhb_pkg::*;

    t_rec                 r_mem [NUM_TAGS];
    t_rec                 r_rd;
    t_rec                 r_byp_rec;
    logic                 r_byp;
    logic [NUM_TAGS-1:0]  r_present;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.rec;
        end
        if (i_rd_en) begin
            r_rd      <= r_mem[i_rd_addr];
            r_byp_rec <= i_wr.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp     <= 1'b0;
            r_present <= '0;
        end else begin
            if (i_rd_en) begin
                r_byp <= i_wr.en && (i_wr.addr == i_rd_addr);
            end
            if (i_wr.en) begin
                r_present[i_wr.addr] <= 1'b1;
            end
        end
    end

    assign o_rec     = r_byp ? r_byp_rec : r_rd;
    assign o_present = r_present[i_look_tag];

endmodule

FILE: rtl/dbhb_decide.sv
// ----------------------------------------------------------------------------
// dbhb_decide
// Forwarding decision against the stored record, record write-back and
// the output register.
// ----------------------------------------------------------------------------
module dbhb_decide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dbhb_pkg::t_item    i_item,
    input  logic               i_item_valid,
    input  dbhb_pkg::t_rec     i_rec,
    input  logic               i_present,
    output logic               o_advance,
    output dbhb_pkg::t_rec_wr  o_wr,
    dbhb_out_if.source         o_out
);
    import dbhb_pkg::*;

    logic signed [DIFF_W-1:0]  v_ext;
    logic signed [DIFF_W-1:0]  l_ext;
    logic signed [DIFF_W-1:0]  d_pos;
    logic signed [DIFF_W-1:0]  d_neg;
    logic [DIFF_W-1:0]         abs_diff;
    logic signed [DIFF_W-1:0]  elapsed;
    logic signed [DIFF_W-1:0]  hb_ext;
    logic                      over_db;
    logic                      hb_due;
    logic                      store;
    logic                      emit;
    logic                      out_free;
    logic                      r_out_valid;
    t_item                     r_out;

    always_comb begin
        v_ext    = {i_item.value[VAL_W-1], i_item.value};
        l_ext    = {i_rec.value[VAL_W-1], i_rec.value};
        d_pos    = v_ext - l_ext;
        d_neg    = l_ext - v_ext;
        abs_diff = d_pos[DIFF_W-1] ? d_neg : d_pos;
        over_db  = abs_diff >= {{(DIFF_W - DB_W){1'b0}}, i_item.deadband};

        elapsed  = i_item.time_ok ? ($signed({1'b0, i_item.time_ms})
                                     - $signed({1'b0, i_rec.time_ms})) : '0;
        hb_ext   = {{(DIFF_W - HB_W){i_item.heartbeat[HB_W-1]}}, i_item.heartbeat};
        hb_due   = i_rec.time_ok && (elapsed >= hb_ext);

        store    = !i_present || (i_item.quality != i_rec.quality)
                   || (i_item.deadband == '0) || over_db || hb_due;
        emit     = i_item.keep && store;
    end

    assign out_free  = !r_out_valid || o_out.ready;
    assign o_advance = i_item_valid && out_free;

    assign o_wr.en           = o_advance && emit;
    assign o_wr.addr         = i_item.tag;
    assign o_wr.rec.value    = i_item.value;
    assign o_wr.rec.quality  = i_item.quality;
    assign o_wr.rec.time_ms  = i_item.time_ms;
    assign o_wr.rec.time_ok  = i_item.time_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && emit) begin
            r_out <= i_item;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.stored_tag        = r_out.tag;
    assign o_out.stored_value      = r_out.value;
    assign o_out.stored_quality    = r_out.quality;
    assign o_out.stored_time_ms    = r_out.time_ms;
    assign o_out.stored_time_valid = r_out.time_ok;

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the deadband and heartbeat storage filter. A table of directed
// samples covers first records, dropped tags, quality changes, zero and
// fallback deadbands, exact deadband hits, heartbeat expiry, timestamps that
// run backwards or are invalid, and the default heartbeat. Random phases under
// several register settings follow, mostly as runs of samples on a few tags
// with small value and time steps. Every store beat is checked field by field
// against an in-bench filter model, with random idling on both sides and one
// long output stall that backs up the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbhb_pkg::*;

    localparam logic signed [VAL_W-1:0]  VAL_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0]  VAL_MIN  = 48'sh8000_0000_0000;
    localparam logic [TIME_W-1:0]        TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [HB_W-1:0]   HB_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [HB_W-1:0]   HB_MIN   = 32'sh8000_0000;
    localparam logic [DB_W-1:0]          DB_TOP   = 47'h7FFF_FFFF_FFFF;
    localparam int                       PHASE_ITEMS = 180;

    typedef enum {VERDICT_MODEL, VERDICT_STORE, VERDICT_DROP} t_verdict;

    typedef struct packed {
        bit [TAG_W-1:0]          tag;
        bit                      known;
        bit signed [VAL_W-1:0]   value;
        bit [QUAL_W-1:0]         quality;
        bit [TIME_W-1:0]         time_ms;
        bit                      time_ok;
        bit signed [VAL_W-1:0]   storage_db;
        bit signed [VAL_W-1:0]   general_db;
        bit signed [HB_W-1:0]    hb;
    } t_sample;

    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [VAL_W-1:0]   value;
        logic [QUAL_W-1:0]         quality;
        logic [TIME_W-1:0]         time_ms;
        logic                      time_ok;
    } t_stored;

    typedef struct {
        t_sample   smp;
        t_verdict  verdict;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    dbhb_in_if  in_if();
    dbhb_out_if out_if();

    deadband_heartbeat_store_filter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bit [DB_W-1:0]           min_db;
    bit signed [HB_W-1:0]    dflt_hb;
    bit                      rec_present [NUM_TAGS];
    bit signed [VAL_W-1:0]   rec_value   [NUM_TAGS];
    bit [QUAL_W-1:0]         rec_quality [NUM_TAGS];
    bit [TIME_W-1:0]         rec_time    [NUM_TAGS];
    bit                      rec_time_ok [NUM_TAGS];

    bit signed [VAL_W-1:0]   gen_value   [NUM_TAGS];
    bit [QUAL_W-1:0]         gen_quality [NUM_TAGS];
    bit [TIME_W-1:0]         gen_time    [NUM_TAGS];

    t_stored    stores_due[$];
    t_dir_row   dir_rows[$];
    t_verdict   row_verdict = VERDICT_MODEL;
    int         mismatches  = 0;
    bit         steady_flow = 1'b0;
    bit         hold_request = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic t_stored as_stored(input t_sample s);
        t_stored r;
        r.tag     = s.tag;
        r.value   = s.value;
        r.quality = s.quality;
        r.time_ms = s.time_ms;
        r.time_ok = s.time_ok;
        return r;
    endfunction

    // Decides whether a sample goes to storage and updates the tag record if so.
    function automatic bit filter_decide(input t_sample s);
        longint local_db;
        longint eff_db;
        longint diff;
        longint elapsed;
        longint hb_lim;
        bit     fwd;
        fwd = 1'b0;
        if (!s.known) begin
            return 1'b0;
        end
        if (!rec_present[s.tag]) begin
            fwd = 1'b1;
        end else if (s.quality != rec_quality[s.tag]) begin
            fwd = 1'b1;
        end else begin
            local_db = longint'(s.storage_db);
            if (local_db < 0) begin
                local_db = longint'(s.general_db);
            end
            if (local_db < 0) begin
                local_db = 0;
            end
            eff_db = (longint'({17'd0, min_db}) > local_db) ? longint'({17'd0, min_db})
                                                            : local_db;
            diff = longint'(s.value) - longint'(rec_value[s.tag]);
            if (diff < 0) begin
                diff = -diff;
            end
            if (eff_db <= 0 || diff >= eff_db) begin
                fwd = 1'b1;
            end else if (rec_time_ok[s.tag]) begin
                elapsed = s.time_ok ? longint'({16'd0, s.time_ms})
                                      - longint'({16'd0, rec_time[s.tag]}) : 0;
                hb_lim = (s.hb >= 0) ? longint'(s.hb) : longint'(dflt_hb);
                fwd = (elapsed >= hb_lim);
            end
        end
        if (fwd) begin
            rec_present[s.tag] = 1'b1;
            rec_value[s.tag]   = s.value;
            rec_quality[s.tag] = s.quality;
            rec_time[s.tag]    = s.time_ms;
            rec_time_ok[s.tag] = s.time_ok;
        end
        return fwd;
    endfunction

    function automatic bit signed [VAL_W-1:0] pick_deadband();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            return {1'b1, 47'({$urandom, $urandom})};
        end else if (pick < 85) begin
            return 48'($urandom_range(0, 4000));
        end else if (pick < 92) begin
            return '0;
        end
        return {1'b0, 47'({$urandom, $urandom})};
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        mismatches++;
        $display("%0t: %s expected %h actual %h", $time, what, want_v, got_v);
    endtask

    task automatic add_row(input bit [TAG_W-1:0] tag, input bit known,
                           input bit signed [VAL_W-1:0] value,
                           input bit [QUAL_W-1:0] quality,
                           input bit [TIME_W-1:0] time_ms, input bit time_ok,
                           input bit signed [VAL_W-1:0] storage_db,
                           input bit signed [VAL_W-1:0] general_db,
                           input bit signed [HB_W-1:0] hb, input t_verdict verdict);
        t_dir_row row;
        row.smp = '{tag: tag, known: known, value: value, quality: quality,
                    time_ms: time_ms, time_ok: time_ok, storage_db: storage_db,
                    general_db: general_db, hb: hb};
        row.verdict = verdict;
        dir_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic drive_sample(input t_sample s);
        while (!steady_flow && $urandom_range(0, 99) < 32) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid                <= 1'b1;
        in_if.tag_index            <= s.tag;
        in_if.tag_known            <= s.known;
        in_if.sample_value         <= s.value;
        in_if.sample_quality       <= s.quality;
        in_if.sample_time_ms       <= s.time_ms;
        in_if.sample_time_valid    <= s.time_ok;
        in_if.tag_storage_deadband <= s.storage_db;
        in_if.tag_general_deadband <= s.general_db;
        in_if.tag_heartbeat_ms     <= s.hb;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (stores_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_limits(input bit [DB_W-1:0] min_v, input bit signed [HB_W-1:0] hb_v);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_GLOBAL_MIN_DB;
        i_cfg_data  <= min_v;
        min_db = min_v;
        @(negedge i_clk);
        i_cfg_index <= CFG_DEFAULT_HB_MS;
        i_cfg_data  <= {15'd0, hb_v};
        dflt_hb = hb_v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        t_sample s;
        int      pick;
        int      delta;
        row_verdict = VERDICT_MODEL;
        for (int n = 0; n < count; n++) begin
            s.tag     = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            s.known   = ($urandom_range(0, 99) >= 5);
            s.quality = ($urandom_range(0, 99) < 85) ? gen_quality[s.tag] : 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                delta   = int'($urandom_range(0, 6000)) - 3000;
                s.value = gen_value[s.tag] + 48'(delta);
            end else if (pick < 70) begin
                s.value = pick[0] ? VAL_MAX : VAL_MIN;
            end else begin
                s.value = 48'({$urandom, $urandom});
            end
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                s.time_ms = gen_time[s.tag] + 48'($urandom_range(0, 1500));
            end else if (pick < 90) begin
                s.time_ms = gen_time[s.tag] - 48'($urandom_range(1, 500));
            end else begin
                s.time_ms = 48'({$urandom, $urandom});
            end
            s.time_ok    = ($urandom_range(0, 99) < 85);
            s.storage_db = pick_deadband();
            s.general_db = pick_deadband();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                s.hb = $urandom_range(0, 2000);
            end else if (pick < 85) begin
                s.hb = {1'b1, 31'($urandom)};
            end else begin
                s.hb = $urandom;
            end
            gen_value[s.tag]   = s.value;
            gen_quality[s.tag] = s.quality;
            gen_time[s.tag]    = s.time_ms;
            drive_sample(s);
        end
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request && hold_left == 0) begin
                hold_request = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= steady_flow || ($urandom_range(0, 99) >= 32);
            end
        end
    end

    always @(posedge i_clk) begin : watch_in
        t_sample s;
        bit      fwd;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            s.tag        = in_if.tag_index;
            s.known      = in_if.tag_known;
            s.value      = in_if.sample_value;
            s.quality    = in_if.sample_quality;
            s.time_ms    = in_if.sample_time_ms;
            s.time_ok    = in_if.sample_time_valid;
            s.storage_db = in_if.tag_storage_deadband;
            s.general_db = in_if.tag_general_deadband;
            s.hb         = in_if.tag_heartbeat_ms;
            fwd = filter_decide(s);
            if (row_verdict == VERDICT_STORE || (row_verdict == VERDICT_MODEL && fwd)) begin
                stores_due.push_back(as_stored(s));
            end
        end
    end

    always @(posedge i_clk) begin : watch_out
        t_stored got;
        t_stored want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.tag     = out_if.stored_tag;
            got.value   = out_if.stored_value;
            got.quality = out_if.stored_quality;
            got.time_ms = out_if.stored_time_ms;
            got.time_ok = out_if.stored_time_valid;
            if (stores_due.size() == 0) begin
                note_mismatch("beat with none due, stored_tag", 'x, got.tag);
            end else begin
                want = stores_due.pop_front();
                if (got.tag !== want.tag)
                    note_mismatch("stored_tag", want.tag, got.tag);
                if (got.value !== want.value)
                    note_mismatch("stored_value", want.value, got.value);
                if (got.quality !== want.quality)
                    note_mismatch("stored_quality", want.quality, got.quality);
                if (got.time_ms !== want.time_ms)
                    note_mismatch("stored_time_ms", want.time_ms, got.time_ms);
                if (got.time_ok !== want.time_ok)
                    note_mismatch("stored_time_valid", want.time_ok, got.time_ok);
            end
        end
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_GLOBAL_MIN_DB;
        i_cfg_data  = '0;
        in_if.valid                = 1'b0;
        in_if.tag_index            = '0;
        in_if.tag_known            = 1'b0;
        in_if.sample_value         = '0;
        in_if.sample_quality       = '0;
        in_if.sample_time_ms       = '0;
        in_if.sample_time_valid    = 1'b0;
        in_if.tag_storage_deadband = '0;
        in_if.tag_general_deadband = '0;
        in_if.tag_heartbeat_ms     = '0;

        add_row(8'd0,   1, VAL_MAX,      8'hFF, TIME_MAX, 1, VAL_MAX, VAL_MAX, HB_MAX,
                VERDICT_STORE);
        add_row(8'd0,   0, VAL_MIN,      8'h00, 48'd0,    0, -48'sd1, -48'sd1, -32'sd1,
                VERDICT_DROP);
        add_row(8'd0,   1, VAL_MAX,      8'hFF, TIME_MAX, 1, -48'sd1, -48'sd1, HB_MAX,
                VERDICT_STORE);
        add_row(8'd0,   1, VAL_MAX,      8'h00, TIME_MAX, 1, VAL_MAX, VAL_MAX, HB_MAX,
                VERDICT_STORE);
        add_row(8'd0,   1, VAL_MIN,      8'h00, 48'd0,    1, 48'sh7FFF_FFFF_FFFF, -48'sd1,
                HB_MAX, VERDICT_MODEL);
        add_row(8'd0,   1, VAL_MIN + 5,  8'h00, 48'd100,  1, 48'sd10, 48'sd0, 32'sd200,
                VERDICT_MODEL);
        add_row(8'd0,   1, VAL_MIN + 5,  8'h00, 48'd200,  1, 48'sd10, 48'sd0, 32'sd200,
                VERDICT_MODEL);
        add_row(8'd0,   1, VAL_MIN + 15, 8'h00, 48'd200,  1, 48'sd10, 48'sd0, HB_MAX,
                VERDICT_MODEL);
        add_row(8'd0,   1, VAL_MIN + 17, 8'h00, 48'd250,  1, -48'sd5, 48'sd3, 32'sd1000,
                VERDICT_MODEL);
        add_row(8'd0,   1, VAL_MIN + 18, 8'h00, 48'd250,  1, -48'sd5, 48'sd3, 32'sd1000,
                VERDICT_MODEL);
        add_row(8'd0,   1, VAL_MIN + 18, 8'h00, 48'd10,   1, 48'sd100, 48'sd0, 32'sd0,
                VERDICT_MODEL);
        add_row(8'd0,   1, VAL_MIN + 18, 8'h00, 48'd10,   0, 48'sd100, 48'sd0, 32'sd0,
                VERDICT_MODEL);
        add_row(8'd0,   1, VAL_MIN + 18, 8'h00, TIME_MAX, 1, 48'sd100, 48'sd0, 32'sd0,
                VERDICT_MODEL);
        add_row(8'd255, 1, VAL_MIN,      8'h5A, TIME_MAX, 1, VAL_MAX, VAL_MIN, HB_MIN,
                VERDICT_STORE);
        add_row(8'd255, 1, VAL_MIN,      8'h5A, TIME_MAX, 1, 48'sd1000, 48'sd0, -32'sd7,
                VERDICT_MODEL);
        add_row(8'd255, 1, VAL_MIN,      8'h5A, 48'd0,    1, 48'sd1000, 48'sd0, HB_MAX,
                VERDICT_MODEL);
        add_row(8'd255, 0, VAL_MAX,      8'hA5, 48'd0,    1, VAL_MIN, VAL_MIN, HB_MIN,
                VERDICT_DROP);
        add_row(8'd255, 1, VAL_MIN,      8'hA5, 48'd0,    1, VAL_MAX, VAL_MAX, HB_MAX,
                VERDICT_STORE);
        add_row(8'd128, 1, 48'sd0,       8'h00, 48'd0,    0, 48'sd0, 48'sd0, 32'sd0,
                VERDICT_STORE);
        add_row(8'd128, 1, 48'sd0,       8'h00, 48'd0,    0, 48'sd0, 48'sd0, 32'sd0,
                VERDICT_STORE);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            row_verdict = dir_rows[i].verdict;
            drive_sample(dir_rows[i].smp);
        end

        set_limits(47'd0, 32'sd500);
        run_phase(PHASE_ITEMS);

        set_limits(DB_TOP, HB_MIN);
        steady_flow  = 1'b1;
        hold_request = 1'b1;
        run_phase(PHASE_ITEMS);
        steady_flow  = 1'b0;

        set_limits(47'h1_0000, HB_MAX);
        run_phase(PHASE_ITEMS);

        set_limits(47'($urandom_range(0, 4000)), $urandom);
        run_phase(PHASE_ITEMS);

        set_limits(47'd0, 32'sd0);
        run_phase(PHASE_ITEMS);

        settle();
        if (mismatches == 0 && stores_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/dbhb_pkg.sv
rtl/dbhb_in_if.sv
rtl/dbhb_out_if.sv
rtl/dbhb_front.sv
rtl/dbhb_records.sv
rtl/dbhb_decide.sv
rtl/deadband_heartbeat_store_filter_top.sv
tb/sv/tb.sv
